### src/htf_pkg.sv
// htf_pkg: widths, register indexes, job record and back-end state type
// for the horizontal three-tap filter. No dependencies.
`default_nettype none

package htf_pkg;

  localparam int PIX_W     = 16;
  localparam int WGT_W     = 8;
  localparam int ROW_W     = 13;
  localparam int ROW_MAX   = 2 ** ROW_W - 1;
  localparam int PROD_W    = 24;
  localparam int NUM_W     = 26;
  localparam int DEN_W     = 10;
  localparam int REM_W     = 9;
  localparam int DIV_BITS  = 24;
  localparam int QDEPTH    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] left_pix;
    logic [PIX_W-1:0] centre_pix;
    logic [PIX_W-1:0] right_pix;
    logic             eor;
    logic             last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_PREP,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

### src/htf_queue.sv
// htf_queue: short job queue between front and back end.
// Depends on htf_pkg (job_t, QDEPTH).
`default_nettype none

module htf_queue import htf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PW = (QDEPTH < 2) ? 1 : $clog2(QDEPTH);

  job_t            mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == (PW+1)'(QDEPTH));
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_job_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("job popped from empty queue");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!push_i && !pop_i) |=> $stable(count_r))
    else $error("queue fill moved without push or pop");

endmodule

`default_nettype wire

### src/htf_front.sv
// htf_front: pixel window, column tracking and job generation.
// Depends on htf_pkg (job_t, widths).
`default_nettype none

module htf_front import htf_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PIX_W-1:0] in_pixel_i,
  input  wire logic [ROW_W-1:0] row_width_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output job_t                  push_job_o
);

  localparam int WLIM = (MAX_WIDTH > ROW_MAX) ? ROW_MAX : MAX_WIDTH;
  localparam int CW   = (MAX_WIDTH > ROW_MAX) ? ROW_W :
                        ((MAX_WIDTH < 2) ? 1 : $clog2(MAX_WIDTH));

  logic [CW-1:0]    col_r, col_nxt;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic [PIX_W-1:0] older_r, older_nxt;
  logic             pend_r, pend_nxt;
  job_t             pend_job_r, pend_job_nxt;
  logic [ROW_W-1:0] w_eff;
  logic [PIX_W-1:0] left_pix;

  always_comb begin
    if (row_width_i == '0) begin
      w_eff = ROW_W'(1);
    end else if (row_width_i > ROW_W'(WLIM)) begin
      w_eff = ROW_W'(WLIM);
    end else begin
      w_eff = row_width_i;
    end
  end

  assign in_ready_o = !pend_r && !full_i;
  assign left_pix   = (col_r == CW'(1)) ? '0 : older_r;

  always_comb begin
    push_o       = 1'b0;
    push_job_o   = '0;
    pend_nxt     = pend_r;
    pend_job_nxt = pend_job_r;
    col_nxt      = col_r;
    prev_nxt     = prev_r;
    older_nxt    = older_r;
    if (pend_r) begin
      if (!full_i) begin
        push_o     = 1'b1;
        push_job_o = pend_job_r;
        pend_nxt   = 1'b0;
      end
    end else if (in_valid_i && !full_i) begin
      older_nxt = prev_r;
      prev_nxt  = in_pixel_i;
      if (w_eff == ROW_W'(1)) begin
        push_o     = 1'b1;
        push_job_o = '{left_pix: '0, centre_pix: in_pixel_i, right_pix: '0,
                       eor: 1'b1, last: 1'b1};
        col_nxt    = '0;
      end else if (col_r == '0) begin
        col_nxt = CW'(1);
      end else if (ROW_W'(col_r) >= w_eff - ROW_W'(1)) begin
        // row ends here: neighbour's result now, own result held pending until the queue has room
        push_o       = 1'b1;
        push_job_o   = '{left_pix: left_pix, centre_pix: prev_r,
                         right_pix: in_pixel_i, eor: 1'b0, last: 1'b0};
        pend_nxt     = 1'b1;
        pend_job_nxt = '{left_pix: prev_r, centre_pix: in_pixel_i, right_pix: '0,
                         eor: 1'b1, last: 1'b1};
        col_nxt      = '0;
      end else begin
        push_o     = 1'b1;
        push_job_o = '{left_pix: left_pix, centre_pix: prev_r,
                       right_pix: in_pixel_i, eor: 1'b0, last: 1'b1};
        col_nxt    = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      prev_r  <= '0;
      older_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      prev_r  <= prev_nxt;
      older_r <= older_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

endmodule

`default_nettype wire

### src/htf_back.sv
// htf_back: weighted sum, serial rounding divider, saturation, output register.
// Depends on htf_pkg (job_t, back_state_t, widths).
`default_nettype none

module htf_back import htf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [WGT_W-1:0] weight_left_i,
  input  wire logic signed [WGT_W-1:0] weight_center_i,
  input  wire logic signed [WGT_W-1:0] weight_right_i,
  input  wire job_t                    head_i,
  input  wire logic                    empty_i,
  output logic                         pop_o,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PIX_W-1:0]      out_filtered,
  output logic                         out_end_of_row,
  output logic                         out_last_of_run,
  output logic                         out_divide_by_zero
);

  localparam int CNT_W = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0] SAT_MAG = DIV_BITS'(2 ** (PIX_W - 1));

  back_state_t             state_r, state_nxt;
  logic signed [PROD_W-1:0] prod_l_r, prod_l_nxt;
  logic signed [PROD_W-1:0] prod_c_r, prod_c_nxt;
  logic signed [PROD_W-1:0] prod_r_r, prod_r_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic [NUM_W-1:0]         num_abs;
  logic [DIV_BITS-1:0]      dvd_r, dvd_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [REM_W+1:0]         diff;
  logic                     neg_r, neg_nxt;
  logic                     eor_r, eor_nxt;
  logic                     last_r, last_nxt;
  logic signed [DEN_W-1:0]  den;
  logic [REM_W-1:0]         ad;
  logic                     den_zero;
  logic [PIX_W-1:0]         sat_val;
  logic                     ov_r, ov_nxt;
  logic [PIX_W-1:0]         of_r, of_nxt;
  logic                     oe_r, oe_nxt;
  logic                     ol_r, ol_nxt;
  logic                     oz_r, oz_nxt;

  assign den      = DEN_W'(weight_left_i) + DEN_W'(weight_center_i)
                  + DEN_W'(weight_right_i);
  assign ad       = den[DEN_W-1] ? REM_W'(-den) : REM_W'(den);
  assign den_zero = (den == '0);
  assign num_abs  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign diff     = {1'b0, rem_r, dvd_r[DIV_BITS-1]} - {2'b00, ad};

  always_comb begin
    if (den_zero) begin
      sat_val = '0;
    end else if (dvd_r >= SAT_MAG) begin
      sat_val = neg_r ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    end else begin
      sat_val = neg_r ? -dvd_r[PIX_W-1:0] : dvd_r[PIX_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pop_o      = 1'b0;
    prod_l_nxt = prod_l_r;
    prod_c_nxt = prod_c_r;
    prod_r_nxt = prod_r_r;
    num_nxt    = num_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    eor_nxt    = eor_r;
    last_nxt   = last_r;
    ov_nxt     = ov_r && !out_ready;
    of_nxt     = of_r;
    oe_nxt     = oe_r;
    ol_nxt     = ol_r;
    oz_nxt     = oz_r;
    case (state_r)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          prod_l_nxt = PROD_W'(weight_left_i) * PROD_W'($signed(head_i.left_pix));
          prod_c_nxt = PROD_W'(weight_center_i) * PROD_W'($signed(head_i.centre_pix));
          prod_r_nxt = PROD_W'(weight_right_i) * PROD_W'($signed(head_i.right_pix));
          eor_nxt    = head_i.eor;
          last_nxt   = head_i.last;
          state_nxt  = B_SUM;
        end
      end
      B_SUM: begin
        num_nxt   = NUM_W'(prod_l_r) + NUM_W'(prod_c_r) + NUM_W'(prod_r_r);
        state_nxt = B_PREP;
      end
      B_PREP: begin
        // magnitude plus half divisor: round to nearest, ties away from zero
        dvd_nxt   = num_abs[DIV_BITS-1:0] + DIV_BITS'(ad >> 1);
        neg_nxt   = num_r[NUM_W-1] ^ den[DEN_W-1];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = den_zero ? B_DONE : B_DIV;
      end
      B_DIV: begin
        if (!diff[REM_W+1]) begin
          rem_nxt = diff[REM_W-1:0];
        end else begin
          rem_nxt = {rem_r[REM_W-2:0], dvd_r[DIV_BITS-1]};
        end
        dvd_nxt = {dvd_r[DIV_BITS-2:0], !diff[REM_W+1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = sat_val;
          oe_nxt    = eor_r;
          ol_nxt    = last_r;
          oz_nxt    = den_zero;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_l_r <= prod_l_nxt;
    prod_c_r <= prod_c_nxt;
    prod_r_r <= prod_r_nxt;
    num_r    <= num_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    eor_r    <= eor_nxt;
    last_r   <= last_nxt;
    of_r     <= of_nxt;
    oe_r     <= oe_nxt;
    ol_r     <= ol_nxt;
    oz_r     <= oz_nxt;
  end

  assign out_valid          = ov_r;
  assign out_filtered       = $signed(of_r);
  assign out_end_of_row     = oe_r;
  assign out_last_of_run    = ol_r;
  assign out_divide_by_zero = oz_r;

endmodule

`default_nettype wire

### src/horizontal_three_tap_filter.sv
// horizontal_three_tap_filter: top level, configuration registers and wiring.
// Depends on htf_pkg, htf_front, htf_queue, htf_back.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_pixel
//   out_     output     out_valid / out_ready  out_filtered, out_end_of_row,
//                                              out_last_of_run, out_divide_by_zero
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each result passes through the back end in order: pop and multiply, sum, round
// prep, 24-bit serial divide, output load; the divide is skipped at zero weight sum.
// Pixels are taken while the four-entry job queue has room; after a row's last
// pixel the input is held off until the row's second job is queued.
// Reset is synchronous, active low: weights 1/2/1, row width 4096, window,
// column, queue and output valid cleared. cfg_ready is always high.
`default_nettype none

module horizontal_three_tap_filter import htf_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        out_filtered,
  output logic                      out_end_of_row,
  output logic                      out_last_of_run,
  output logic                      out_divide_by_zero,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data
);

  logic signed [WGT_W-1:0] weight_left_r;
  logic signed [WGT_W-1:0] weight_center_r;
  logic signed [WGT_W-1:0] weight_right_r;
  logic [ROW_W-1:0]        row_width_r;
  logic                    push;
  job_t                    push_job;
  logic                    pop;
  job_t                    head;
  logic                    q_empty;
  logic                    q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_left_r   <= WGT_W'(1);
      weight_center_r <= WGT_W'(2);
      weight_right_r  <= WGT_W'(1);
      row_width_r     <= ROW_W'(4096);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_LEFT:   weight_left_r   <= $signed(cfg_data[WGT_W-1:0]);
        REG_WEIGHT_CENTER: weight_center_r <= $signed(cfg_data[WGT_W-1:0]);
        REG_WEIGHT_RIGHT:  weight_right_r  <= $signed(cfg_data[WGT_W-1:0]);
        REG_ROW_WIDTH:     row_width_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  htf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_pixel_i  (in_pixel),
    .row_width_i (row_width_r),
    .full_i      (q_full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  htf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  htf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .weight_left_i      (weight_left_r),
    .weight_center_i    (weight_center_r),
    .weight_right_i     (weight_right_r),
    .head_i             (head),
    .empty_i            (q_empty),
    .pop_o              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered       (out_filtered),
    .out_end_of_row     (out_end_of_row),
    .out_last_of_run    (out_last_of_run),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

`default_nettype wire
